[rtl/mcspg_pkg.sv]
// Package: shared types, codes and constants for the servo pulse generator.
package mcspg_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned ModeW  = 2;
  localparam int unsigned ChanW  = 3;
  localparam int unsigned AngleW = 16;
  localparam int unsigned PulseW = 16;
  localparam int unsigned PinsW  = 8;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned MinW     = 12;
  localparam int unsigned CpuW     = 6;
  localparam int unsigned FrameW   = 16;

  // Default channel count.
  localparam int unsigned DefaultChannels = 8;

  // Register reset values.
  localparam logic [MinW-1:0]   MinPulseReset   = 12'd92;
  localparam logic [MinW-1:0]   MaxPulseReset   = 12'd150;
  localparam logic [CpuW-1:0]   CyclesPerUsReset = 6'd16;
  localparam logic [FrameW-1:0] FrameTicksReset = 16'd5000;

  // Largest accepted angle in degrees.
  localparam logic [7:0] AngleMax = 8'd180;

  // Reciprocal of 45 for inputs below 2**28: floor(y/45) = (y * Recip45) >> 34.
  localparam int unsigned DivInW    = 28;
  localparam int unsigned RecipShift = 34;
  localparam longint unsigned Recip45 = ((64'd1 << RecipShift) + 64'd44) / 64'd45;
  localparam int unsigned RecipW    = 29;

  // Item modes.
  localparam logic [ModeW-1:0] ModeSet     = 2'd0;
  localparam logic [ModeW-1:0] ModeDisable = 2'd1;
  localparam logic [ModeW-1:0] ModeTick    = 2'd2;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] RegMinPulse   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMaxPulse   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegCyclesPerUs = 2'd2;
  localparam logic [CfgIdxW-1:0] RegFrameTicks = 2'd3;

  // Input item.
  typedef struct packed {
    logic [ModeW-1:0]         mode;
    logic [ChanW-1:0]         channel;
    logic signed [AngleW-1:0] angle;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [PinsW-1:0]  pin_levels;
    logic              frame_start;
    logic [PulseW-1:0] pulse_ticks;
  } out_item_t;

  // Controller states, one-hot.
  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StMul1   = 5'b00010,
    StMul2   = 5'b00100,
    StDiv    = 5'b01000,
    StCommit = 5'b10000
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic idle;
    logic load;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_set;
    logic out_free;
  } status_t;

endpackage

[rtl/multi_channel_servo_pulse_generator_core.sv]
// Top level: multi-channel servo pulse generator, controller plus datapath.
// A tick, disable, unused-mode or out-of-range set item goes from acceptance straight to
// commit; a set-angle item first passes three multiply/reciprocal stages, then commits.
// The block takes a new item only once the last one is committed: one item is in flight
// at a time, and a stalled result holds the commit and the input.
// Reset (asynchronous, active low) clears all channel pulses, the frame counter,
// the pins and the result valid flag, and loads register defaults 92, 150, 16, 5000.
module multi_channel_servo_pulse_generator_core #(
  parameter int unsigned CHANNELS = mcspg_pkg::DefaultChannels
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mcspg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mcspg_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  mcspg_pkg::in_item_t            in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output mcspg_pkg::out_item_t           out_item_o
);

  mcspg_pkg::cmd_t    cmd;
  mcspg_pkg::status_t status;

  // Sequencer.
  mcspg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Arithmetic, channel state and result register.
  mcspg_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

  assign in_stall_o = !cmd.idle;

endmodule

[rtl/mcspg_ctrl.sv]
// Controller: sequences one item from acceptance through pulse math to commit.
module mcspg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  mcspg_pkg::status_t status_i,
  output mcspg_pkg::cmd_t    cmd_o
);

  mcspg_pkg::state_e state_q, state_d;

  // Commands decoded from the current state.
  always_comb begin
    cmd_o.idle   = (state_q == mcspg_pkg::StIdle);
    cmd_o.load   = cmd_o.idle && in_valid_i;
    cmd_o.commit = (state_q == mcspg_pkg::StCommit) && status_i.out_free;
  end

  // Set-angle items for an existing channel walk the multiply and divide stages; others go straight to commit.
  always_comb begin
    state_d = state_q;
    case (state_q)
      mcspg_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = mcspg_pkg::StCommit;
        end
      end
      mcspg_pkg::StMul1:   state_d = mcspg_pkg::StMul2;
      mcspg_pkg::StMul2:   state_d = mcspg_pkg::StDiv;
      mcspg_pkg::StDiv:    state_d = mcspg_pkg::StCommit;
      mcspg_pkg::StCommit: begin
        if (status_i.out_free) begin
          state_d = mcspg_pkg::StIdle;
        end
      end
      default: state_d = mcspg_pkg::StIdle;
    endcase
    // The mode is decoded from the input item, not the latched one, so divert here.
    if (state_q == mcspg_pkg::StIdle && in_valid_i && status_i.is_set) begin
      state_d = mcspg_pkg::StMul1;
    end
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mcspg_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[rtl/mcspg_datapath.sv]
// Datapath: configuration, pulse arithmetic, channel state and result register.
module mcspg_datapath #(
  parameter int unsigned CHANNELS = mcspg_pkg::DefaultChannels
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mcspg_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [mcspg_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  mcspg_pkg::in_item_t               in_item_i,
  input  mcspg_pkg::cmd_t                   cmd_i,
  output mcspg_pkg::status_t                status_o,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output mcspg_pkg::out_item_t              out_item_o
);

  localparam int unsigned PadW = (CHANNELS > mcspg_pkg::PinsW) ? CHANNELS : mcspg_pkg::PinsW;
  localparam int unsigned SpanW = mcspg_pkg::MinW + 1;
  localparam int unsigned M1W   = 21;
  localparam int unsigned M2W   = 27;
  localparam int unsigned MagW  = M2W - 1;
  localparam int unsigned ProdW = mcspg_pkg::DivInW + mcspg_pkg::RecipW;
  localparam int unsigned QuoW  = ProdW - mcspg_pkg::RecipShift;
  localparam int unsigned BaseW = mcspg_pkg::MinW + mcspg_pkg::CpuW;
  localparam int unsigned SumW  = QuoW + 2;
  localparam int unsigned ShW   = SumW - 1 - 6;

  // Configuration registers.
  logic [mcspg_pkg::MinW-1:0]   min_q, max_q;
  logic [mcspg_pkg::CpuW-1:0]   cpu_q;
  logic [mcspg_pkg::FrameW-1:0] frame_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q         <= mcspg_pkg::MinPulseReset;
      max_q         <= mcspg_pkg::MaxPulseReset;
      cpu_q         <= mcspg_pkg::CyclesPerUsReset;
      frame_ticks_q <= mcspg_pkg::FrameTicksReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mcspg_pkg::RegMinPulse:    min_q         <= cfg_wdata_i[mcspg_pkg::MinW-1:0];
        mcspg_pkg::RegMaxPulse:    max_q         <= cfg_wdata_i[mcspg_pkg::MinW-1:0];
        mcspg_pkg::RegCyclesPerUs: cpu_q         <= cfg_wdata_i[mcspg_pkg::CpuW-1:0];
        mcspg_pkg::RegFrameTicks:  frame_ticks_q <= cfg_wdata_i[mcspg_pkg::FrameW-1:0];
        default: ;
      endcase
    end
  end

  // Latched item fields; the angle is clamped to 0..180 on the way in.
  logic [mcspg_pkg::ModeW-1:0] mode_q;
  logic [mcspg_pkg::ChanW-1:0] chan_q;
  logic [7:0]                  ang_q, ang_d;
  logic                        chan_ok_q;

  always_comb begin
    if (in_item_i.angle < 0) begin
      ang_d = '0;
    end else if (in_item_i.angle > $signed({8'd0, mcspg_pkg::AngleMax})) begin
      ang_d = mcspg_pkg::AngleMax;
    end else begin
      ang_d = in_item_i.angle[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q    <= in_item_i.mode;
      chan_q    <= in_item_i.channel;
      ang_q     <= ang_d;
      chan_ok_q <= (32'(in_item_i.channel) < CHANNELS);
    end
  end

  assign status_o.is_set = (in_item_i.mode == mcspg_pkg::ModeSet) &&
                           (32'(in_item_i.channel) < CHANNELS);

  // Pulse arithmetic stages: span*angle, then *cpu, then /45 by reciprocal.
  logic signed [SpanW-1:0] span;
  logic signed [M1W-1:0]   m1_q, span_ext, ang_ext;
  logic signed [M2W-1:0]   m2_q, m1_ext, cpu_ext;
  logic [BaseW-1:0]        base_q;
  logic [MagW-1:0]         mag;
  logic [ProdW-1:0]        prod;
  logic [QuoW-1:0]         quo_q;
  logic                    neg_q;

  always_comb begin
    span     = $signed({1'b0, max_q}) - $signed({1'b0, min_q});
    span_ext = M1W'(span);
    ang_ext  = $signed({{(M1W-8){1'b0}}, ang_q});
    m1_ext   = M2W'(m1_q);
    cpu_ext  = $signed({{(M2W-mcspg_pkg::CpuW){1'b0}}, cpu_q});
    mag      = m2_q[M2W-1] ? MagW'(-m2_q) : m2_q[MagW-1:0];
    prod     = ProdW'({mag, 2'b00}) * ProdW'(mcspg_pkg::Recip45);
  end

  always_ff @(posedge clk_i) begin
    m1_q   <= M1W'(span_ext * ang_ext);
    base_q <= BaseW'(min_q) * BaseW'(cpu_q);
    m2_q   <= M2W'(m1_ext * cpu_ext);
    quo_q  <= prod[ProdW-1:mcspg_pkg::RecipShift];
    neg_q  <= m2_q[M2W-1];
  end

  // Final sum, divide by 64, clamp negative to zero and saturate high.
  logic signed [SumW-1:0]       sum;
  logic [ShW-1:0]               sh;
  logic [mcspg_pkg::PulseW-1:0] pulse;

  always_comb begin
    sum = $signed(SumW'({base_q, 4'b0000}));
    if (neg_q) begin
      sum = sum - $signed(SumW'(quo_q));
    end else begin
      sum = sum + $signed(SumW'(quo_q));
    end
    sh = sum[SumW-2:6];
    if (sum[SumW-1]) begin
      pulse = '0;
    end else if (sh > ShW'(16'hFFFF)) begin
      pulse = '1;
    end else begin
      pulse = sh[mcspg_pkg::PulseW-1:0];
    end
  end

  // Channel state.
  logic [mcspg_pkg::PulseW-1:0] pending_q [CHANNELS];
  logic [mcspg_pkg::PulseW-1:0] frame_pulse_q [CHANNELS];
  logic [mcspg_pkg::FrameW-1:0] elapsed_q, elapsed_d;
  logic [CHANNELS-1:0]          pins_q, pins_d;
  logic [mcspg_pkg::FrameW:0]   elapsed_inc;
  logic                         is_tick, is_write, start;
  logic [mcspg_pkg::PulseW-1:0] new_pulse, pulse_out;

  always_comb begin
    is_tick     = (mode_q == mcspg_pkg::ModeTick);
    is_write    = ((mode_q == mcspg_pkg::ModeSet) || (mode_q == mcspg_pkg::ModeDisable)) &&
                  chan_ok_q;
    new_pulse   = (mode_q == mcspg_pkg::ModeSet) ? pulse : '0;
    pulse_out   = is_write ? new_pulse : '0;
    start       = is_tick && (elapsed_q == '0);
    elapsed_inc = {1'b0, elapsed_q} + 1'b1;
    elapsed_d   = (elapsed_inc >= {1'b0, frame_ticks_q}) ? '0
                                                         : elapsed_inc[mcspg_pkg::FrameW-1:0];
    pins_d = pins_q;
    if (is_tick) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (start) begin
          pins_d[c] = (pending_q[c] != '0);
        end else if (elapsed_q > frame_pulse_q[c]) begin
          pins_d[c] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        pending_q[c]     <= '0;
        frame_pulse_q[c] <= '0;
      end
      elapsed_q <= '0;
      pins_q    <= '0;
    end else if (cmd_i.commit) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (is_write && (32'(chan_q) == c)) begin
          pending_q[c] <= new_pulse;
        end
        if (start) begin
          frame_pulse_q[c] <= pending_q[c];
        end
      end
      if (is_tick) begin
        elapsed_q <= elapsed_d;
      end
      pins_q <= pins_d;
    end
  end

  // Result register, loaded on commit.
  logic                 out_valid_q;
  mcspg_pkg::out_item_t out_q;
  logic [PadW-1:0]      pins_pad;

  assign pins_pad           = PadW'(pins_d);
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q.pin_levels  <= pins_pad[mcspg_pkg::PinsW-1:0];
      out_q.frame_start <= start;
      out_q.pulse_ticks <= pulse_out;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
